// ===== sv/imh_pkg.sv =====
// Shared types, command and status codes, and key compare for the indexed max-heap engine.
package imh_pkg;

  // Default sizing handed to the top level.
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_WEIGHT_BITS = 32;

  // Fixed port widths.
  localparam int NODE_W   = 10;
  localparam int KEY_IN_W = 32;
  localparam int COUNT_W  = 11;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int KEY_MAX_BITS = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Memory read selects.
  typedef enum logic [3:0] {
    RD_NONE,
    RD_POS,
    RD_IDX,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT,
    RD_BIDX,
    RD_ZERO
  } rd_op_t;

  // Memory write selects.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_DROP,
    WR_APPEND,
    WR_RD,
    WR_A,
    WR_B
  } wr_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic                cap;
    rd_op_t              rd;
    wr_op_t              wr;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                a_from_in;
    logic                a_from_rd;
    logic                b_from_a;
    logic                b_cmp;
    logic                idx_from_pos;
    logic                idx_from_rd;
    logic                idx_from_b;
    logic                idx_from_bidx;
    logic                bidx_load;
    logic                bidx_dec;
    logic                moved_clr;
    logic                moved_set;
    logic                st_load;
    logic [STATUS_W-1:0] st_val;
    logic                out_load;
  } dp_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             present;
    logic             full;
    logic             cnt_zero;
    logic             is_last;
    logic             idx_zero;
    logic             left_ok;
    logic             right_ok;
    logic             a_beats_rd;
    logic             old_beats_new;
    logic             pick;
    logic             moved;
    logic             bidx_zero;
    logic             clr_last;
    logic             out_busy;
  } dp_stat_t;

  // Entry A beats entry B on the larger primary key, then on the larger secondary key.
  function automatic logic key_beats(input logic [KEY_MAX_BITS-1:0] am,
                                     input logic [KEY_MAX_BITS-1:0] as,
                                     input logic [KEY_MAX_BITS-1:0] bm,
                                     input logic [KEY_MAX_BITS-1:0] bs);
    logic r;
    if (am != bm) begin
      r = am > bm;
    end else begin
      r = as > bs;
    end
    return r;
  endfunction

endpackage

// ===== sv/indexed_max_heap_engine_core.sv =====
// Update and remove sift the moved entry up or down, one level at a time, before the result loads.
// Build sifts down each slot from live_count/2 back to the root before the result loads.
// Only one beat is in work at a time; the next can be taken in the cycle after the result loads.
// After reset a clearing pass marks every node absent before in_ready rises.
// Synchronous active-high reset empties the heap; slot contents stay undefined until written.
module indexed_max_heap_engine_core import imh_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node_id,
  input  logic [KEY_IN_W-1:0] key_max,
  input  logic [KEY_IN_W-1:0] key_sum,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   top_node,
  output logic                top_valid,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [STATUS_W-1:0] status
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // Sequencer.
  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Heap storage and result register.
  imh_dpath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (command),
    .node_id     (node_id),
    .key_max     (key_max),
    .key_sum     (key_sum),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .top_node    (top_node),
    .top_valid   (top_valid),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule

// ===== sv/imh_dpath.sv =====
// Datapath of the indexed max-heap engine: slot and position memories, sift registers, result.
module imh_dpath import imh_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_ctl_t             ctl,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node_id,
  input  logic [KEY_IN_W-1:0] key_max,
  input  logic [KEY_IN_W-1:0] key_sum,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [NODE_W-1:0]   top_node,
  output logic                top_valid,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [STATUS_W-1:0] status
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int XW = IW + 2;
  localparam int W  = WEIGHT_BITS;

  // Heap slot memories and node position memory.
  logic [NODE_W-1:0] slot_node_mem [MAX_NODES];
  logic [W-1:0]      slot_km_mem   [MAX_NODES];
  logic [W-1:0]      slot_ks_mem   [MAX_NODES];
  logic [CW-1:0]     pos_mem       [MAX_NODES];

  // Captured command beat.
  logic [CMD_W-1:0]  in_cmd;
  logic [NODE_W-1:0] in_node;
  logic [W-1:0]      in_km;
  logic [W-1:0]      in_ks;

  // Heap state and sift registers.
  logic [CW-1:0]     cnt;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     b_idx;
  logic [IW-1:0]     bidx;
  logic [IW-1:0]     clr_idx;
  logic [NODE_W-1:0] a_node;
  logic [W-1:0]      a_km;
  logic [W-1:0]      a_ks;
  logic [NODE_W-1:0] b_node;
  logic [W-1:0]      b_km;
  logic [W-1:0]      b_ks;
  logic              pick;
  logic              moved;
  logic [STATUS_W-1:0] st;

  // Registered read data.
  logic [CW-1:0]     pos_q;
  logic [NODE_W-1:0] q_node;
  logic [W-1:0]      q_km;
  logic [W-1:0]      q_ks;

  // Address arithmetic and write port muxes.
  logic [IW-1:0]     node_addr;
  logic [XW-1:0]     left;
  logic [XW-1:0]     right;
  logic [IW-1:0]     parent;
  logic              slot_re;
  logic [IW-1:0]     slot_ra;
  logic              slot_we;
  logic [IW-1:0]     slot_wa;
  logic [NODE_W-1:0] slot_wn;
  logic [W-1:0]      slot_wm;
  logic [W-1:0]      slot_ws;
  logic              pos_we;
  logic [IW-1:0]     pos_wa;
  logic [CW-1:0]     pos_wd;

  assign node_addr = IW'(in_node);
  assign left      = (XW'(idx) << 1) | XW'(1);
  assign right     = left + XW'(1);
  assign parent    = (idx - IW'(1)) >> 1;

  // Status toward the controller.
  always_comb begin
    stat.cmd           = in_cmd;
    stat.in_range      = 32'(in_node) < 32'(MAX_NODES);
    stat.present       = stat.in_range && (pos_q < cnt);
    stat.full          = cnt == CW'(MAX_NODES);
    stat.cnt_zero      = cnt == '0;
    stat.is_last       = CW'(idx) == (cnt - CW'(1));
    stat.idx_zero      = idx == '0;
    stat.left_ok       = left < XW'(cnt);
    stat.right_ok      = right < XW'(cnt);
    stat.a_beats_rd    = key_beats(KEY_MAX_BITS'(a_km), KEY_MAX_BITS'(a_ks),
                                   KEY_MAX_BITS'(q_km), KEY_MAX_BITS'(q_ks));
    stat.old_beats_new = key_beats(KEY_MAX_BITS'(q_km), KEY_MAX_BITS'(q_ks),
                                   KEY_MAX_BITS'(in_km), KEY_MAX_BITS'(in_ks));
    stat.pick          = pick;
    stat.moved         = moved;
    stat.bidx_zero     = bidx == '0;
    stat.clr_last      = clr_idx == IW'(MAX_NODES - 1);
    stat.out_busy      = out_valid && !out_ready;
  end

  // Slot read address select.
  always_comb begin
    slot_re = 1'b1;
    case (ctl.rd)
      RD_IDX:    slot_ra = idx;
      RD_LAST:   slot_ra = IW'(cnt - CW'(1));
      RD_PARENT: slot_ra = parent;
      RD_LEFT:   slot_ra = IW'(left);
      RD_RIGHT:  slot_ra = IW'(right);
      RD_BIDX:   slot_ra = bidx;
      RD_ZERO:   slot_ra = '0;
      default: begin
        slot_ra = '0;
        slot_re = 1'b0;
      end
    endcase
  end

  // Write port select for both memories.
  always_comb begin
    slot_we = 1'b0;
    slot_wa = idx;
    slot_wn = a_node;
    slot_wm = a_km;
    slot_ws = a_ks;
    pos_we  = 1'b0;
    pos_wa  = IW'(a_node);
    pos_wd  = CW'(idx);
    case (ctl.wr)
      WR_CLEAR: begin
        pos_we = 1'b1;
        pos_wa = clr_idx;
        pos_wd = CW'(MAX_NODES);
      end
      WR_DROP: begin
        pos_we = 1'b1;
        pos_wa = node_addr;
        pos_wd = CW'(MAX_NODES);
      end
      WR_APPEND: begin
        slot_we = 1'b1;
        slot_wa = IW'(cnt);
        slot_wn = in_node;
        slot_wm = in_km;
        slot_ws = in_ks;
        pos_we  = 1'b1;
        pos_wa  = node_addr;
        pos_wd  = cnt;
      end
      WR_RD: begin
        slot_we = 1'b1;
        slot_wn = q_node;
        slot_wm = q_km;
        slot_ws = q_ks;
        pos_we  = 1'b1;
        pos_wa  = IW'(q_node);
      end
      WR_A: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      WR_B: begin
        slot_we = 1'b1;
        slot_wn = b_node;
        slot_wm = b_km;
        slot_ws = b_ks;
        pos_we  = 1'b1;
        pos_wa  = IW'(b_node);
      end
      default: begin
        slot_we = 1'b0;
        pos_we  = 1'b0;
      end
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_node_mem[slot_wa] <= slot_wn;
      slot_km_mem[slot_wa]   <= slot_wm;
      slot_ks_mem[slot_wa]   <= slot_ws;
    end
    if (slot_re) begin
      q_node <= slot_node_mem[slot_ra];
      q_km   <= slot_km_mem[slot_ra];
      q_ks   <= slot_ks_mem[slot_ra];
      rd_idx <= slot_ra;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (ctl.rd == RD_POS) begin
      pos_q <= pos_mem[node_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      moved     <= 1'b0;
      pick      <= 1'b0;
    end else begin
      if (ctl.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (ctl.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (ctl.wr == WR_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.moved_clr) begin
        moved <= 1'b0;
      end else if (ctl.moved_set) begin
        moved <= 1'b1;
      end
      if (ctl.b_from_a) begin
        pick <= 1'b0;
      end else if (ctl.b_cmp && key_beats(KEY_MAX_BITS'(q_km), KEY_MAX_BITS'(q_ks),
                                          KEY_MAX_BITS'(b_km), KEY_MAX_BITS'(b_ks))) begin
        pick <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      in_cmd  <= command;
      in_node <= node_id;
      in_km   <= W'(key_max);
      in_ks   <= W'(key_sum);
    end
    if (ctl.a_from_in) begin
      a_node <= in_node;
      a_km   <= in_km;
      a_ks   <= in_ks;
    end else if (ctl.a_from_rd) begin
      a_node <= q_node;
      a_km   <= q_km;
      a_ks   <= q_ks;
    end
    if (ctl.b_from_a) begin
      b_node <= a_node;
      b_km   <= a_km;
      b_ks   <= a_ks;
      b_idx  <= idx;
    end else if (ctl.b_cmp && key_beats(KEY_MAX_BITS'(q_km), KEY_MAX_BITS'(q_ks),
                                        KEY_MAX_BITS'(b_km), KEY_MAX_BITS'(b_ks))) begin
      b_node <= q_node;
      b_km   <= q_km;
      b_ks   <= q_ks;
      b_idx  <= rd_idx;
    end
    if (ctl.idx_from_pos) begin
      idx <= IW'(pos_q);
    end else if (ctl.idx_from_rd) begin
      idx <= rd_idx;
    end else if (ctl.idx_from_b) begin
      idx <= b_idx;
    end else if (ctl.idx_from_bidx) begin
      idx <= bidx;
    end
    if (ctl.bidx_load) begin
      bidx <= IW'(cnt >> 1);
    end else if (ctl.bidx_dec) begin
      bidx <= bidx - IW'(1);
    end
    if (ctl.st_load) begin
      st <= ctl.st_val;
    end
    if (ctl.out_load) begin
      top_node    <= (cnt != '0) ? q_node : '0;
      top_valid   <= cnt != '0;
      entry_count <= COUNT_W'(cnt);
      status      <= st;
    end
  end

  // An append never grows a full heap.
  assert property (@(posedge clk) disable iff (rst) ctl.cnt_inc |-> !stat.full)
    else $error("append issued on a full heap");

  // A sift-down step only moves a child that won the compare.
  assert property (@(posedge clk) disable iff (rst) (ctl.wr == WR_B) |-> pick)
    else $error("sift-down moved a child that did not win");

  // A new result never overwrites one still waiting to be taken.
  assert property (@(posedge clk) disable iff (rst) ctl.out_load |-> !stat.out_busy)
    else $error("result register overwritten while stalled");

endmodule

// ===== sv/imh_ctrl.sv =====
// Controller state machine of the indexed max-heap engine: command decode and sift sequencing.
module imh_ctrl import imh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_LOOKW,
    S_UPD_RD,
    S_UPD_W,
    S_REM_RD,
    S_REM_W,
    S_UP_RD,
    S_UP_W,
    S_DN_RD,
    S_DN_RL,
    S_DN_RR,
    S_DN_DEC,
    S_PLACE,
    S_BLD_RD,
    S_BLD_W,
    S_FIN,
    S_FIN_W
  } state_t;

  typedef enum logic [1:0] {
    M_UPD,
    M_REM,
    M_BLD
  } mode_t;

  state_t state;
  state_t state_next;
  mode_t  mode;
  mode_t  mode_next;

  assign in_ready = state == S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    mode_next  = mode;
    ctl        = '0;
    ctl.rd     = RD_NONE;
    ctl.wr     = WR_NONE;
    ctl.st_val = ST_OK;
    unique case (state)
      S_CLEAR: begin
        ctl.wr = WR_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap    = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.rd     = RD_POS;
        state_next = S_LOOKW;
      end
      S_LOOKW: begin
        ctl.st_load = 1'b1;
        state_next  = S_FIN;
        unique case (stat.cmd)
          CMD_APPEND: begin
            if (!stat.in_range) begin
              ctl.st_val = ST_ABSENT;
            end else if (stat.present) begin
              ctl.idx_from_pos = 1'b1;
              mode_next        = M_UPD;
              state_next       = S_UPD_RD;
            end else if (stat.full) begin
              ctl.st_val = ST_FULL;
            end else begin
              ctl.wr      = WR_APPEND;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_BUILD: begin
            if (!stat.cnt_zero) begin
              ctl.bidx_load = 1'b1;
              mode_next     = M_BLD;
              state_next    = S_BLD_RD;
            end
          end
          CMD_REMOVE: begin
            if (!stat.present) begin
              ctl.st_val = ST_ABSENT;
            end else begin
              ctl.idx_from_pos = 1'b1;
              mode_next        = M_REM;
              state_next       = S_REM_RD;
            end
          end
          CMD_UPDATE: begin
            if (!stat.present) begin
              ctl.st_val = ST_ABSENT;
            end else begin
              ctl.idx_from_pos = 1'b1;
              mode_next        = M_UPD;
              state_next       = S_UPD_RD;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      // Key update: compare the old key, then sift the new entry.
      S_UPD_RD: begin
        ctl.rd     = RD_IDX;
        state_next = S_UPD_W;
      end
      S_UPD_W: begin
        ctl.a_from_in = 1'b1;
        ctl.moved_clr = 1'b1;
        state_next    = stat.old_beats_new ? S_DN_RD : S_UP_RD;
      end
      // Removal: fetch the last entry, drop the node, sift the moved entry.
      S_REM_RD: begin
        ctl.rd     = RD_LAST;
        ctl.wr     = WR_DROP;
        state_next = S_REM_W;
      end
      S_REM_W: begin
        ctl.cnt_dec = 1'b1;
        if (stat.is_last) begin
          state_next = S_FIN;
        end else begin
          ctl.a_from_rd = 1'b1;
          ctl.moved_clr = 1'b1;
          state_next    = S_UP_RD;
        end
      end
      // Sift up: the moving entry waits in a register while parents move down.
      S_UP_RD: begin
        if (stat.idx_zero) begin
          state_next = (mode == M_REM && !stat.moved) ? S_DN_RD : S_PLACE;
        end else begin
          ctl.rd     = RD_PARENT;
          state_next = S_UP_W;
        end
      end
      S_UP_W: begin
        if (stat.a_beats_rd) begin
          ctl.wr          = WR_RD;
          ctl.idx_from_rd = 1'b1;
          ctl.moved_set   = 1'b1;
          state_next      = S_UP_RD;
        end else begin
          state_next = (mode == M_REM && !stat.moved) ? S_DN_RD : S_PLACE;
        end
      end
      // Sift down: read the left child and any right child, keep the winner, move it up.
      S_DN_RD: begin
        if (!stat.left_ok) begin
          state_next = S_PLACE;
        end else begin
          ctl.rd       = RD_LEFT;
          ctl.b_from_a = 1'b1;
          state_next   = S_DN_RL;
        end
      end
      S_DN_RL: begin
        ctl.b_cmp = 1'b1;
        if (stat.right_ok) begin
          ctl.rd     = RD_RIGHT;
          state_next = S_DN_RR;
        end else begin
          state_next = S_DN_DEC;
        end
      end
      S_DN_RR: begin
        ctl.b_cmp  = 1'b1;
        state_next = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (stat.pick) begin
          ctl.wr         = WR_B;
          ctl.idx_from_b = 1'b1;
          state_next     = S_DN_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      // Write the moving entry into its final slot.
      S_PLACE: begin
        ctl.wr     = WR_A;
        state_next = S_FIN;
        if (mode == M_BLD && !stat.bidx_zero) begin
          ctl.bidx_dec = 1'b1;
          state_next   = S_BLD_RD;
        end
      end
      // Build: sift down each inner slot from the middle back to the root.
      S_BLD_RD: begin
        ctl.rd            = RD_BIDX;
        ctl.idx_from_bidx = 1'b1;
        state_next        = S_BLD_W;
      end
      S_BLD_W: begin
        ctl.a_from_rd = 1'b1;
        state_next    = S_DN_RD;
      end
      // Read the root and load the result register.
      S_FIN: begin
        ctl.rd     = RD_ZERO;
        state_next = S_FIN_W;
      end
      S_FIN_W: begin
        if (stat.out_busy) begin
          ctl.rd = RD_ZERO;
        end else begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mode  <= M_UPD;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // One command beat is in work at a time.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second command accepted while one is in work");

  // Dropping a node from the position table only happens for a present node.
  assert property (@(posedge clk) disable iff (rst) (ctl.wr == WR_DROP) |-> stat.present)
    else $error("removal of an absent node");

  // The entry count only shrinks on a removal of a present node.
  assert property (@(posedge clk) disable iff (rst) ctl.cnt_dec |-> stat.present)
    else $error("entry count decremented without a present node");

endmodule

// ===== test/indexed_max_heap_engine_core_checker.sv =====
// Result checker for the indexed max-heap engine: mirrors the heap and compares every result beat.
module indexed_max_heap_engine_core_checker import imh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node_id,
  input  logic [KEY_IN_W-1:0] key_max,
  input  logic [KEY_IN_W-1:0] key_sum,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [NODE_W-1:0]   top_node,
  input  logic                top_valid,
  input  logic [COUNT_W-1:0]  entry_count,
  input  logic [STATUS_W-1:0] status,
  output int                  fail_count,
  output int                  pending_count
);

  localparam int NODES = DEF_MAX_NODES;

  typedef struct packed {
    logic [NODE_W-1:0]   top_node;
    logic                top_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } heap_view_t;

  // Mirror of the heap held in the block.
  logic [NODE_W-1:0]   heap_node [NODES];
  logic [KEY_IN_W-1:0] heap_kmax [NODES];
  logic [KEY_IN_W-1:0] heap_ksum [NODES];
  int                  node_slot [NODES];
  int                  heap_size;
  heap_view_t          view_queue [$];

  function automatic bit outranks(logic [KEY_IN_W-1:0] am, logic [KEY_IN_W-1:0] as,
                                  logic [KEY_IN_W-1:0] bm, logic [KEY_IN_W-1:0] bs);
    if (am != bm) return am > bm;
    return as > bs;
  endfunction

  function automatic bit slot_outranks(int a, int b);
    return outranks(heap_kmax[a], heap_ksum[a], heap_kmax[b], heap_ksum[b]);
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [NODE_W-1:0]   n;
    logic [KEY_IN_W-1:0] m;
    logic [KEY_IN_W-1:0] s;
    n = heap_node[a]; m = heap_kmax[a]; s = heap_ksum[a];
    heap_node[a] = heap_node[b]; heap_kmax[a] = heap_kmax[b]; heap_ksum[a] = heap_ksum[b];
    heap_node[b] = n; heap_kmax[b] = m; heap_ksum[b] = s;
    node_slot[heap_node[a]] = a;
    node_slot[heap_node[b]] = b;
  endfunction

  function automatic void raise_entry(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!slot_outranks(i, p)) return;
      swap_entries(i, p);
      i = p;
    end
  endfunction

  function automatic void lower_entry(int i);
    int best;
    forever begin
      best = i;
      if (2*i+1 < heap_size && slot_outranks(2*i+1, best)) best = 2*i+1;
      if (2*i+2 < heap_size && slot_outranks(2*i+2, best)) best = 2*i+2;
      if (best == i) return;
      swap_entries(i, best);
      i = best;
    end
  endfunction

  function automatic void rekey(int pos, logic [KEY_IN_W-1:0] m, logic [KEY_IN_W-1:0] s);
    bit drop;
    drop = outranks(heap_kmax[pos], heap_ksum[pos], m, s);
    heap_kmax[pos] = m;
    heap_ksum[pos] = s;
    if (drop) lower_entry(pos);
    else raise_entry(pos);
  endfunction

  // Applies one command beat and returns the heap view it should produce.
  function automatic heap_view_t apply_command(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                                               logic [KEY_IN_W-1:0] m, logic [KEY_IN_W-1:0] s);
    heap_view_t v;
    int  pos;
    int  last;
    logic [NODE_W-1:0] moved;
    bit  present;
    v = '0;
    pos = node_slot[node];
    present = pos < heap_size;
    case (cmd)
      CMD_APPEND: begin
        if (present) rekey(pos, m, s);
        else if (heap_size >= NODES) v.status = ST_FULL;
        else begin
          heap_node[heap_size] = node;
          heap_kmax[heap_size] = m;
          heap_ksum[heap_size] = s;
          node_slot[node] = heap_size;
          heap_size++;
        end
      end
      CMD_BUILD: begin
        if (heap_size > 0)
          for (int i = heap_size / 2; i >= 0; i--) lower_entry(i);
      end
      CMD_REMOVE: begin
        if (!present) v.status = ST_ABSENT;
        else begin
          last = heap_size - 1;
          if (pos != last) swap_entries(pos, last);
          node_slot[node] = NODES;
          heap_size = last;
          if (pos < heap_size) begin
            moved = heap_node[pos];
            raise_entry(pos);
            if (heap_node[pos] == moved) lower_entry(pos);
          end
        end
      end
      CMD_UPDATE: begin
        if (!present) v.status = ST_ABSENT;
        else rekey(pos, m, s);
      end
      default: ;
    endcase
    v.top_valid   = heap_size > 0;
    v.top_node    = heap_size > 0 ? heap_node[0] : '0;
    v.entry_count = heap_size[COUNT_W-1:0];
    return v;
  endfunction

  assign pending_count = view_queue.size();

  // Predict on each command beat, compare on each result beat.
  always @(posedge clk) begin
    heap_view_t want;
    if (rst) begin
      heap_size = 0;
      fail_count <= 0;
      view_queue.delete();
      for (int i = 0; i < NODES; i++) node_slot[i] = NODES;
    end else begin
      if (out_valid && out_ready) begin
        if (view_queue.size() == 0) begin
          $error("result beat with no command waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = view_queue.pop_front();
          if (top_valid !== want.top_valid) begin
            $error("top_valid: expected %0d, got %0d", want.top_valid, top_valid);
            fail_count <= fail_count + 1;
          end
          if (top_node !== want.top_node) begin
            $error("top_node: expected %0d, got %0d", want.top_node, top_node);
            fail_count <= fail_count + 1;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            fail_count <= fail_count + 1;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        view_queue.push_back(apply_command(command, node_id, key_max, key_sum));
      end
    end
  end

endmodule

// ===== test/indexed_max_heap_engine_core_test.sv =====
// Testbench top for the indexed max-heap engine: stimulus, receiver stalls and the verdict.
module indexed_max_heap_engine_core_test;
  import imh_pkg::*;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [NODE_W-1:0]   node_id;
  logic [KEY_IN_W-1:0] key_max;
  logic [KEY_IN_W-1:0] key_sum;
  logic                out_valid;
  logic                out_ready;
  logic [NODE_W-1:0]   top_node;
  logic                top_valid;
  logic [COUNT_W-1:0]  entry_count;
  logic [STATUS_W-1:0] status;
  int                  fail_count;
  int                  pending_count;
  int                  cycle_count;
  bit                  hold_receiver;

  localparam int CYCLE_LIMIT = 3000000;

  indexed_max_heap_engine_core i_dut (
    .clk, .rst, .in_valid, .in_ready, .command, .node_id, .key_max, .key_sum,
    .out_valid, .out_ready, .top_node, .top_valid, .entry_count, .status
  );

  indexed_max_heap_engine_core_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .command, .node_id, .key_max, .key_sum,
    .out_valid, .out_ready, .top_node, .top_valid, .entry_count, .status,
    .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, and one long hold when asked.
  initial begin
    int gap;
    bit held;
    out_ready = 0;
    held = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_receiver && !held) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        held = 1;
      end
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
      if ($urandom_range(3) == 0) gap = 0;
      out_ready <= (gap == 0);
      @(posedge clk);
    end
  end

  // Sends one command beat and waits for the edge that accepts it.
  task automatic send_beat(logic [CMD_W-1:0] c, logic [NODE_W-1:0] n,
                           logic [KEY_IN_W-1:0] m, logic [KEY_IN_W-1:0] s, bit idle_ok);
    int gap;
    gap = 0;
    if (idle_ok) gap = ($urandom_range(15) == 0) ? $urandom_range(30) : $urandom_range(3);
    if (idle_ok && $urandom_range(2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command  <= c;
    node_id  <= n;
    key_max  <= m;
    key_sum  <= s;
    @(posedge clk iff in_ready);
  endtask

  // Key values: small ones so ties on key_max occur, extremes, or fully random half the time.
  function automatic logic [KEY_IN_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] c;
    int               span;
    rst = 1;
    in_valid = 0;
    command = CMD_PEEK;
    node_id = '0;
    key_max = '0;
    key_sum = '0;
    hold_receiver = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: empty heap, absent nodes, extremes, ties, each command.
    send_beat(CMD_PEEK, 0, 0, 0, 0);
    send_beat(CMD_BUILD, 0, 0, 0, 0);
    send_beat(CMD_REMOVE, 10'd5, 0, 0, 0);
    send_beat(CMD_UPDATE, 10'h3FF, 0, 0, 0);
    send_beat(CMD_APPEND, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(CMD_APPEND, 10'd0, 32'h0, 32'h0, 0);
    send_beat(CMD_APPEND, 10'd7, 32'h5, 32'h9, 0);
    send_beat(CMD_APPEND, 10'd8, 32'h5, 32'h3, 0);
    send_beat(CMD_APPEND, 10'd9, 32'hFFFF_FFFF, 32'h0, 0);
    send_beat(CMD_BUILD, 0, 0, 0, 0);
    send_beat(CMD_APPEND, 10'd7, 32'h0, 32'h1, 0);
    send_beat(CMD_UPDATE, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(CMD_UPDATE, 10'd8, 32'h5, 32'h3, 0);
    send_beat(CMD_REMOVE, 10'd0, 0, 0, 0);
    send_beat(CMD_REMOVE, 10'd0, 0, 0, 0);
    send_beat(3'd5, 0, 0, 0, 0);
    send_beat(3'd6, 0, 0, 0, 0);
    send_beat(3'd7, 0, 0, 0, 0);
    send_beat(CMD_REMOVE, 10'h3FF, 0, 0, 0);
    send_beat(CMD_PEEK, 0, 0, 0, 0);

    // Fill the heap to capacity, then update a node in the full heap; the receiver holds off at the start.
    hold_receiver = 1;
    for (int n = 0; n < 1024; n++) begin
      send_beat(CMD_APPEND, NODE_W'(n), pick_key(), pick_key(), 0);
    end
    send_beat(CMD_APPEND, 10'd1000, 1, 1, 0);
    send_beat(CMD_BUILD, 0, 0, 0, 0);
    wait_drained();

    // Random phase over a small node range so hits dominate.
    for (int k = 0; k < 600; k++) begin
      if (k == 300) wait_drained();
      span = ($urandom_range(9) == 0) ? 1023 : 63;
      c = $urandom_range(9) == 0 ? CMD_BUILD
        : $urandom_range(9) == 0 ? CMD_W'($urandom_range(7))
        : $urandom_range(3) == 0 ? CMD_APPEND : $urandom_range(2) ? CMD_UPDATE : CMD_REMOVE;
      send_beat(c, NODE_W'($urandom_range(span)), pick_key(), pick_key(), 1);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
